// ===== rtl/core/msrr_pkg.sv =====
// Shared types and constants for the minimal standard random range unit.
`default_nettype none

package msrr_pkg;

  localparam int unsigned STATE_W = 31;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = STATE_W + MULT_W;
  localparam int unsigned STEP_W  = 5;

  localparam logic [STATE_W-1:0] PM_MODULUS = 31'h7FFF_FFFF;
  localparam logic [MULT_W-1:0]  PM_MULT    = 15'd16807;
  localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;
  localparam logic [STEP_W-1:0]  LAST_STEP  = 5'd30;

  localparam logic CMD_RAW   = 1'b0;
  localparam logic CMD_RANGE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               range_error;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic advance;
    logic div_step;
    logic load_rsp;
  } ctl_t;

  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/msrr_ctrl.sv =====
// Sequencer for request capture, state advance, remainder steps and result hand-off.
`default_nettype none

module msrr_ctrl
  import msrr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADV,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    ctl          = '0;
    ctl.load_req = (state == S_IDLE) && cmd_valid;
    ctl.advance  = (state == S_ADV);
    ctl.div_step = (state == S_DIV);
    ctl.load_rsp = (state == S_FIN) && rsp_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          step  <= '0;
          state <= sts.need_div ? S_DIV : S_FIN;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msrr_dp.sv =====
// Generator state, Mersenne reduction, bounds ordering and restoring remainder unit.
`default_nettype none

module msrr_dp
  import msrr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               seed_wr_en,
  input  wire logic [STATE_W-1:0] seed_wr_data,
  input  wire req_t               cmd_word,
  input  wire ctl_t               ctl,
  output sts_t                    sts,
  output rsp_t                    rsp_word
);

  logic [STATE_W-1:0] gen_state;
  logic [PROD_W-1:0]  prod;
  logic               need_div;
  logic               err;
  logic signed [31:0] lo_q;
  logic [STATE_W-1:0] span_q;
  logic [STATE_W-1:0] dvd;
  logic [STATE_W-1:0] rem;

  logic signed [31:0] lo_ord;
  logic signed [31:0] hi_ord;
  logic [32:0]        span_full;
  logic               span_err;
  logic [31:0]        fold;
  logic [STATE_W-1:0] state_next;
  logic [31:0]        trial;
  logic [31:0]        trial_diff;

  assign sts.need_div = need_div;

  always_comb begin
    if (cmd_word.low_bound > cmd_word.high_bound) begin
      lo_ord = cmd_word.high_bound;
      hi_ord = cmd_word.low_bound;
    end else begin
      lo_ord = cmd_word.low_bound;
      hi_ord = cmd_word.high_bound;
    end
    span_full = {hi_ord[31], hi_ord} - {lo_ord[31], lo_ord} + 33'd1;
    span_err  = span_full > {2'b00, PM_MODULUS};
  end

  // fold the product modulo 2^31-1; zero maps to the modulus
  always_comb begin
    fold = {1'b0, prod[STATE_W-1:0]} + {{(32-MULT_W){1'b0}}, prod[PROD_W-1:STATE_W]};
    if (fold > {1'b0, PM_MODULUS}) begin
      state_next = STATE_W'(fold - {1'b0, PM_MODULUS});
    end else if (fold == 32'd0) begin
      state_next = PM_MODULUS;
    end else begin
      state_next = fold[STATE_W-1:0];
    end
  end

  assign trial      = {rem, dvd[STATE_W-1]};
  assign trial_diff = trial - {1'b0, span_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
    end else if (seed_wr_en) begin
      gen_state <= seed_wr_data;
    end else if (ctl.advance) begin
      gen_state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      prod     <= {{MULT_W{1'b0}}, gen_state} * PM_MULT;
      need_div <= (cmd_word.cmd == CMD_RANGE) && !span_err;
      err      <= (cmd_word.cmd == CMD_RANGE) && span_err;
      lo_q     <= lo_ord;
      span_q   <= span_full[STATE_W-1:0];
    end
    if (ctl.advance) begin
      dvd <= state_next;
      rem <= '0;
    end else if (ctl.div_step) begin
      dvd <= {dvd[STATE_W-2:0], 1'b0};
      if (trial >= {1'b0, span_q}) begin
        rem <= trial_diff[STATE_W-1:0];
      end else begin
        rem <= trial[STATE_W-1:0];
      end
    end
    if (ctl.load_rsp) begin
      rsp_word.range_error <= err;
      if (need_div) begin
        rsp_word.value <= lo_q + signed'({1'b0, rem});
      end else begin
        rsp_word.value <= signed'({1'b0, gen_state});
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/minimal_standard_random_range_unit.sv =====
// Top level of the minimal standard random range unit.
// Each accepted word advances the 31-bit generator (16807 * state mod 2^31-1, zero
// mapped to 2^31-1) and returns one result word: the raw draw for cmd 0, or for
// cmd 1 low + (draw mod span) over the ordered bounds, with range_error set and the
// raw draw returned when the span exceeds 2^31-1. One word is in flight at a time.
// A raw or out-of-range word passes through the advance and finish states; a bounded
// word also passes through the restoring remainder unit, which retires one dividend bit
// per cycle over 31 bits. A new word is accepted while the previous result still
// waits in the output register. Writing seed_wr_data reloads the generator state;
// the state resets to 1.
`default_nettype none

module minimal_standard_random_range_unit
  import msrr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               seed_wr_en,
  input  wire logic [STATE_W-1:0] seed_wr_data,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire req_t               cmd_word,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp_word
);

  ctl_t ctl;
  sts_t sts;

  msrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  msrr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .cmd_word     (cmd_word),
    .ctl          (ctl),
    .sts          (sts),
    .rsp_word     (rsp_word)
  );

endmodule

`default_nettype wire

// ===== rtl/core/msrr_chk.sv =====
// Port-level checks for the minimal standard random range unit, bound to the top level.
`default_nettype none

module msrr_chk
  import msrr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               seed_wr_en,
  input wire logic [STATE_W-1:0] seed_wr_data,
  input wire logic               cmd_valid,
  input wire logic               cmd_stall,
  input wire req_t               cmd_word,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire rsp_t               rsp_word
);

  logic cmd_take;

  assign cmd_take = cmd_valid && !cmd_stall;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("result word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> cmd_stall)
    else $error("second word taken while one is in progress");

  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> !$rose(rsp_valid))
    else $error("result appeared the cycle after acceptance");

  a_err_raw: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.range_error |-> !rsp_word.value[31] && (rsp_word.value != 32'sd0))
    else $error("range error result is not a raw draw");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid && !cmd_stall)
    else $error("reset left the unit busy");

endmodule

bind minimal_standard_random_range_unit msrr_chk u_chk (.*);

`default_nettype wire
